// ----- rtl/core/fc_pkg.sv -----
// Shared types, widths and codes for the FIR full-convolution block.
// Used by fc_front, fc_back and fir_full_convolution; depends on nothing.
package fc_pkg;

  localparam int DATA_W       = 16;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int OUT_W        = 40;
  localparam int IDX_W        = 6;
  localparam int TAPCNT_W     = 7;
  localparam int MAX_TAPS_DEF = 64;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic REG_TAP_COUNT = 1'b0;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = TAPCNT_W'(1);

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DROP,
    CMD_SAMPLE,
    CMD_LAST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [IDX_W-1:0]          slot;
    logic signed [DATA_W-1:0]  value;
    logic [TAPCNT_W-1:0]       taps;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

endpackage

// ----- rtl/core/fc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module fc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fc_front.sv -----
// Input side: accepts items, classifies them into commands and queues them.
// Depends on fc_pkg.
module fc_front import fc_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [IDX_W-1:0]         in_tap_index,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_block_end,
  input  logic [TAPCNT_W-1:0]      taps_eff,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  logic                     cmd_ready,
  output q_status_t                q_stat
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              new_cmd;
  logic              push, pop;

  always_comb begin
    new_cmd.slot  = in_tap_index;
    new_cmd.value = in_value;
    new_cmd.taps  = taps_eff;
    priority if (in_operation == OP_LOAD) begin
      new_cmd.kind = (int'(in_tap_index) < MAX_TAPS) ? CMD_LOAD : CMD_DROP;
    end else if (in_block_end) begin
      new_cmd.kind = CMD_LAST;
    end else begin
      new_cmd.kind = CMD_SAMPLE;
    end
  end

  assign in_ready     = (cnt_r != QCNT_W'(QDEPTH));
  assign cmd_valid    = (cnt_r != '0);
  assign cmd          = q_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = !in_ready;
  assign push         = in_valid && in_ready;
  assign pop          = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- rtl/core/fc_back.sv -----
// Execution side: coefficient store, circular sample history and one shared
// multiply-accumulate sequenced over the taps. Depends on fc_pkg and fc_ram.
module fc_back import fc_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  output logic                    cmd_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_filtered,
  output logic                    out_final_output
);

  localparam int HAW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int HDEPTH = 1 << HAW;

  back_state_t          state_r, state_nxt;
  logic [HAW-1:0]       wp_r, wp_nxt;
  logic [TAPCNT_W-1:0]  fill_r, fill_nxt;
  logic [TAPCNT_W-1:0]  idx_r, idx_nxt;
  logic [TAPCNT_W-1:0]  tail_r, tail_nxt;
  logic [TAPCNT_W-1:0]  taps_r, taps_nxt;
  logic                 last_r, last_nxt;
  logic                 final_r, final_nxt;
  logic [DATA_W-1:0]    smp_r, smp_nxt;
  logic [OUT_W-1:0]     acc_r, acc_nxt;
  logic                 p1_v_r, p1_v_nxt;
  logic                 p1_ok_r, p1_ok_nxt;
  logic                 p2_v_r, p2_v_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 ov_r, ov_nxt;
  logic [OUT_W-1:0]     of_r, of_nxt;
  logic                 ofin_r, ofin_nxt;

  logic                 cw_en, hw_en;
  logic [HAW-1:0]       hw_addr, h_raddr, c_raddr;
  logic [DATA_W-1:0]    hw_data, c_q, h_q;

  fc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_coef (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cmd.slot[HAW-1:0]),
    .wdata (cmd.value),
    .raddr (c_raddr),
    .rdata (c_q)
  );

  fc_ram #(.WIDTH(DATA_W), .DEPTH(HDEPTH)) u_hist (
    .clk   (clk),
    .we    (hw_en),
    .waddr (hw_addr),
    .wdata (hw_data),
    .raddr (h_raddr),
    .rdata (h_q)
  );

  assign c_raddr          = idx_r[HAW-1:0];
  assign h_raddr          = wp_r - idx_r[HAW-1:0];
  assign hw_addr          = wp_r + HAW'(1);
  assign hw_data          = (tail_r == '0) ? smp_r : '0;
  assign out_valid        = ov_r;
  assign out_filtered     = of_r;
  assign out_final_output = ofin_r;

  always_comb begin
    p2_v_nxt = p1_v_r;
    prod_nxt = p1_ok_r ? PROD_W'($signed(c_q) * $signed(h_q)) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    tail_nxt  = tail_r;
    taps_nxt  = taps_r;
    last_nxt  = last_r;
    final_nxt = final_r;
    smp_nxt   = smp_r;
    acc_nxt   = p2_v_r ? acc_r + {{(OUT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} : acc_r;
    p1_v_nxt  = 1'b0;
    p1_ok_nxt = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    of_nxt    = of_r;
    ofin_nxt  = ofin_r;
    cmd_ready = 1'b0;
    cw_en     = 1'b0;
    hw_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_LOAD: cw_en = 1'b1;
            CMD_DROP: ;
            CMD_SAMPLE, CMD_LAST: begin
              smp_nxt   = cmd.value;
              taps_nxt  = cmd.taps;
              last_nxt  = (cmd.kind == CMD_LAST);
              tail_nxt  = '0;
              state_nxt = ST_PUSH;
            end
          endcase
        end
      end
      ST_PUSH: begin
        hw_en     = 1'b1;
        wp_nxt    = hw_addr;
        fill_nxt  = (int'(fill_r) < MAX_TAPS) ? fill_r + TAPCNT_W'(1) : fill_r;
        acc_nxt   = '0;
        idx_nxt   = '0;
        final_nxt = last_r && (tail_r == taps_r - TAPCNT_W'(1));
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        p1_v_nxt  = 1'b1;
        p1_ok_nxt = (idx_r < fill_r);
        idx_nxt   = idx_r + TAPCNT_W'(1);
        if (idx_r == taps_r - TAPCNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          of_nxt   = acc_r;
          ofin_nxt = final_r;
          priority if (final_r) begin
            fill_nxt  = '0;
            state_nxt = ST_IDLE;
          end else if (last_r) begin
            tail_nxt  = tail_r + TAPCNT_W'(1);
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      p1_v_r  <= p1_v_nxt;
      p2_v_r  <= p2_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    tail_r  <= tail_nxt;
    taps_r  <= taps_nxt;
    last_r  <= last_nxt;
    final_r <= final_nxt;
    smp_r   <= smp_nxt;
    acc_r   <= acc_nxt;
    p1_ok_r <= p1_ok_nxt;
    prod_r  <= prod_nxt;
    of_r    <= of_nxt;
    ofin_r  <= ofin_nxt;
  end

endmodule

// ----- rtl/core/fir_full_convolution.sv -----
// A coefficient load passes the command queue and is written into the store when
// the execution side takes it while idle. A sample result passes the queue, the
// history write, the single MAC that walks the taps one per cycle and the drain
// of the MAC pipeline; each tail result of a block end repeats the write, walk
// and drain. No new sample is taken before the last result is emitted. Reset is
// synchronous, active low; the history reads as zero through its fill count.
module fir_full_convolution import fc_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [IDX_W-1:0]         in_tap_index,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_block_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_filtered,
  output logic                     out_final_output
);

  logic [TAPCNT_W-1:0] tap_count_r, tap_count_nxt;
  logic [TAPCNT_W-1:0] taps_eff;
  logic                cfg_wr;
  logic                cmd_valid, cmd_ready;
  cmd_t                cmd;
  q_status_t           q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TAP_COUNT) ? APB_DW'(tap_count_r) : '0;

  always_comb begin
    tap_count_nxt = tap_count_r;
    if (cfg_wr && (paddr[2] == REG_TAP_COUNT)) begin
      tap_count_nxt = pwdata[TAPCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else begin
      tap_count_r <= tap_count_nxt;
    end
  end

  always_comb begin
    priority if (tap_count_r == '0) begin
      taps_eff = TAPCNT_W'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      taps_eff = TAPCNT_W'(MAX_TAPS);
    end else begin
      taps_eff = tap_count_r;
    end
  end

  fc_front #(.MAX_TAPS(MAX_TAPS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_tap_index (in_tap_index),
    .in_value     (in_value),
    .in_block_end (in_block_end),
    .taps_eff     (taps_eff),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready),
    .q_stat       (q_stat)
  );

  fc_back #(.MAX_TAPS(MAX_TAPS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_ready        (cmd_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered     (out_filtered),
    .out_final_output (out_final_output)
  );

  a_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
    (taps_eff != '0) && (int'(taps_eff) <= MAX_TAPS))
    else $error("effective tap count out of range");

  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !q_stat.empty)
    else $error("accepted item missing from command queue");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !cmd_ready) |=> !in_ready)
    else $error("input ready while command queue stays full");

endmodule
